>>> hdl/s20x_pkg.sv
// ----------------------------------------------------------------------------
// s20x_pkg
// Shared constants, tables and helpers for the Salsa20 byte stream engine.
// ----------------------------------------------------------------------------
package s20x_pkg;

  // rounds per keystream block and the double-round count derived from it
  localparam int unsigned ROUND_COUNT = 20;
  localparam int unsigned DR_COUNT    = (ROUND_COUNT + 1) / 2;
  localparam int unsigned DR_W        = (DR_COUNT > 1) ? $clog2(DR_COUNT) : 1;
  localparam logic [DR_W-1:0] DR_LAST = DR_W'(DR_COUNT - 1);
  localparam logic [DR_W-1:0] DR_ONE  = DR_W'(1);

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  // rotate amounts of the four quarter-round steps
  localparam int unsigned ROT0 = 7;
  localparam int unsigned ROT1 = 9;
  localparam int unsigned ROT2 = 13;
  localparam int unsigned ROT3 = 18;

  // configuration register indexes
  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_KEY3  = 3'd3;
  localparam logic [2:0] REG_NONCE = 3'd4;

  typedef logic [3:0] widx_t;

  // word indexes a, b, c, d of each quarter round: four column, then four row
  localparam widx_t QR_IDX [8][4] = '{
    '{4'd0,  4'd4,  4'd8,  4'd12},
    '{4'd5,  4'd9,  4'd13, 4'd1 },
    '{4'd10, 4'd14, 4'd2,  4'd6 },
    '{4'd15, 4'd3,  4'd7,  4'd11},
    '{4'd0,  4'd1,  4'd2,  4'd3 },
    '{4'd5,  4'd6,  4'd7,  4'd4 },
    '{4'd10, 4'd11, 4'd8,  4'd9 },
    '{4'd15, 4'd12, 4'd13, 4'd14}
  };

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [1:0] sel);
    logic [31:0] r;
    case (sel)
      2'd0:    r = (v << ROT0) | (v >> (32 - ROT0));
      2'd1:    r = (v << ROT1) | (v >> (32 - ROT1));
      2'd2:    r = (v << ROT2) | (v >> (32 - ROT2));
      default: r = (v << ROT3) | (v >> (32 - ROT3));
    endcase
    return r;
  endfunction

  // initial state word from constants, key, nonce and block counter
  function automatic logic [31:0] init_word(
    input widx_t       idx,
    input logic [63:0] k0,
    input logic [63:0] k1,
    input logic [63:0] k2,
    input logic [63:0] k3,
    input logic [63:0] nonce,
    input logic [63:0] ctr
  );
    logic [31:0] w;
    case (idx)
      4'd0:    w = SIGMA0;
      4'd1:    w = k0[31:0];
      4'd2:    w = k0[63:32];
      4'd3:    w = k1[31:0];
      4'd4:    w = k1[63:32];
      4'd5:    w = SIGMA1;
      4'd6:    w = nonce[31:0];
      4'd7:    w = nonce[63:32];
      4'd8:    w = ctr[31:0];
      4'd9:    w = ctr[63:32];
      4'd10:   w = SIGMA2;
      4'd11:   w = k2[31:0];
      4'd12:   w = k2[63:32];
      4'd13:   w = k3[31:0];
      4'd14:   w = k3[63:32];
      default: w = SIGMA3;
    endcase
    return w;
  endfunction

endpackage

>>> hdl/salsa20_stream_xor_engine_top.sv
// ----------------------------------------------------------------------------
// salsa20_stream_xor_engine_top
// Salsa20 byte stream engine: xors each byte with the next keystream byte.
// ----------------------------------------------------------------------------
// A byte whose keystream is already on hand goes from acceptance through the
// keystream word read to the result load, which waits while the output stalls.
// When a new 64-byte block is needed, the byte first waits for block generation:
// loading the 16 initial state words, the 8 * (ROUND_COUNT+1)/2 quarter rounds
// (two word reads, then four add-rotate-xor steps on the one shared 32-bit
// adder, each writing its word back), and the final add. The engine takes no
// new byte while one is in flight; a finished result waits in the output
// register while the next byte is accepted. Key and nonce are written over the
// APB port at byte addresses 0, 8, 16, 24 (key) and 32 (nonce).
// ----------------------------------------------------------------------------
module salsa20_stream_xor_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_in_i,
  input  logic        restart_i,
  // byte output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_out_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_LD0  = 3'd2;
  localparam logic [2:0] ST_LD1  = 3'd3;
  localparam logic [2:0] ST_QR   = 3'd4;
  localparam logic [2:0] ST_FADD = 3'd5;
  localparam logic [2:0] ST_KRD  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam logic [1:0] STEP_B = 2'd0;
  localparam logic [1:0] STEP_C = 2'd1;
  localparam logic [1:0] STEP_D = 2'd2;
  localparam logic [1:0] STEP_A = 2'd3;

  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_q;
  logic        cfg_wr;

  logic [2:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [2:0]  qr_q, qr_d;
  logic [s20x_pkg::DR_W-1:0] dr_q, dr_d;
  logic [1:0]  step_q, step_d;
  logic [63:0] ctr_q, ctr_d;
  logic [5:0]  rem_q, rem_d;
  logic [7:0]  data_q, data_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_data_q, out_data_d;
  logic [31:0] qa_q, qa_d, qb_q, qb_d, qc_q, qc_d, qd_q, qd_d;

  // working state and finished keystream block share one memory
  logic [31:0]           ws_mem [16];
  logic                  ws_we;
  s20x_pkg::widx_t       ws_waddr, raddr_a, raddr_b;
  logic [31:0]           ws_wdata, rd_a_q, rd_b_q;

  s20x_pkg::widx_t       init_sel, fadd_addr;
  logic [31:0]           init_val;
  logic [31:0]           add_x, add_y, add_t, sum, qr_res;
  logic [5:0]            kidx;
  logic [7:0]            ks_byte;
  logic                  out_free;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q  <= '0;
      key1_q  <= '0;
      key2_q  <= '0;
      key3_q  <= '0;
      nonce_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        s20x_pkg::REG_KEY0:  key0_q  <= pwdata;
        s20x_pkg::REG_KEY1:  key1_q  <= pwdata;
        s20x_pkg::REG_KEY2:  key2_q  <= pwdata;
        s20x_pkg::REG_KEY3:  key3_q  <= pwdata;
        s20x_pkg::REG_NONCE: nonce_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      s20x_pkg::REG_KEY0:  prdata = key0_q;
      s20x_pkg::REG_KEY1:  prdata = key1_q;
      s20x_pkg::REG_KEY2:  prdata = key2_q;
      s20x_pkg::REG_KEY3:  prdata = key3_q;
      s20x_pkg::REG_NONCE: prdata = nonce_q;
      default:             prdata = '0;
    endcase
  end

  // state memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (ws_we) begin
      ws_mem[ws_waddr] <= ws_wdata;
    end
    rd_a_q <= ws_mem[raddr_a];
    rd_b_q <= ws_mem[raddr_b];
  end

  // shared add / rotate / xor unit
  assign fadd_addr = s20x_pkg::widx_t'(cnt_q - 5'd1);
  assign init_sel  = (state_q == ST_FADD) ? fadd_addr : cnt_q[3:0];
  assign init_val  = s20x_pkg::init_word(init_sel, key0_q, key1_q, key2_q, key3_q,
                                         nonce_q, ctr_q);
  assign sum       = add_x + add_y;
  assign qr_res    = add_t ^ s20x_pkg::rotl32(sum, step_q);

  // index of the next keystream byte in the block
  assign kidx = 6'd0 - rem_q;

  always_comb begin
    case (kidx[1:0])
      2'd0:    ks_byte = rd_a_q[7:0];
      2'd1:    ks_byte = rd_a_q[15:8];
      2'd2:    ks_byte = rd_a_q[23:16];
      default: ks_byte = rd_a_q[31:24];
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    qr_d        = qr_q;
    dr_d        = dr_q;
    step_d      = step_q;
    ctr_d       = ctr_q;
    rem_d       = rem_q;
    data_d      = data_q;
    qa_d        = qa_q;
    qb_d        = qb_q;
    qc_d        = qc_q;
    qd_d        = qd_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q & out_stall_i;
    ws_we       = 1'b0;
    ws_waddr    = cnt_q[3:0];
    ws_wdata    = init_val;
    raddr_a     = kidx[5:2];
    raddr_b     = s20x_pkg::QR_IDX[qr_q][3];
    add_x       = qa_q;
    add_y       = qd_q;
    add_t       = qb_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          data_d = data_in_i;
          if (restart_i) begin
            ctr_d = '0;
            rem_d = '0;
          end
          if (restart_i || rem_q == 6'd0) begin
            cnt_d   = '0;
            state_d = ST_INIT;
          end else begin
            state_d = ST_KRD;
          end
        end
      end
      ST_INIT: begin
        ws_we = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q[3:0] == 4'd15) begin
          cnt_d   = '0;
          qr_d    = '0;
          dr_d    = '0;
          state_d = ST_LD0;
        end
      end
      ST_LD0: begin
        raddr_a = s20x_pkg::QR_IDX[qr_q][0];
        raddr_b = s20x_pkg::QR_IDX[qr_q][3];
        state_d = ST_LD1;
      end
      ST_LD1: begin
        raddr_a = s20x_pkg::QR_IDX[qr_q][1];
        raddr_b = s20x_pkg::QR_IDX[qr_q][2];
        qa_d    = rd_a_q;
        qd_d    = rd_b_q;
        step_d  = STEP_B;
        state_d = ST_QR;
      end
      ST_QR: begin
        ws_we    = 1'b1;
        ws_wdata = qr_res;
        step_d   = step_q + 2'd1;
        case (step_q)
          STEP_B: begin
            add_x    = qa_q;
            add_y    = qd_q;
            add_t    = rd_a_q;
            ws_waddr = s20x_pkg::QR_IDX[qr_q][1];
            qb_d     = qr_res;
            qc_d     = rd_b_q;
          end
          STEP_C: begin
            add_x    = qb_q;
            add_y    = qa_q;
            add_t    = qc_q;
            ws_waddr = s20x_pkg::QR_IDX[qr_q][2];
            qc_d     = qr_res;
          end
          STEP_D: begin
            add_x    = qc_q;
            add_y    = qb_q;
            add_t    = qd_q;
            ws_waddr = s20x_pkg::QR_IDX[qr_q][3];
            qd_d     = qr_res;
          end
          default: begin
            add_x    = qd_q;
            add_y    = qc_q;
            add_t    = qa_q;
            ws_waddr = s20x_pkg::QR_IDX[qr_q][0];
            qa_d     = qr_res;
            qr_d     = qr_q + 3'd1;
            state_d  = ST_LD0;
            if (qr_q == 3'd7) begin
              if (dr_q == s20x_pkg::DR_LAST) begin
                cnt_d   = '0;
                state_d = ST_FADD;
              end else begin
                dr_d = dr_q + s20x_pkg::DR_ONE;
              end
            end
          end
        endcase
      end
      ST_FADD: begin
        // read word n while word n-1 gets its initial value added back
        if (!cnt_q[4]) begin
          raddr_a = cnt_q[3:0];
        end
        add_x = rd_a_q;
        add_y = init_val;
        if (cnt_q != 5'd0) begin
          ws_we    = 1'b1;
          ws_waddr = fadd_addr;
          ws_wdata = sum;
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q[4]) begin
          ctr_d   = ctr_q + 64'd1;
          state_d = ST_KRD;
        end
      end
      ST_KRD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_data_d  = data_q ^ ks_byte;
          out_valid_d = 1'b1;
          rem_d       = rem_q - 6'd1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      qr_q        <= '0;
      dr_q        <= '0;
      step_q      <= STEP_B;
      ctr_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      qr_q        <= qr_d;
      dr_q        <= dr_d;
      step_q      <= step_d;
      ctr_q       <= ctr_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    out_data_q <= out_data_d;
    qa_q       <= qa_d;
    qb_q       <= qb_d;
    qc_q       <= qc_d;
    qd_q       <= qd_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;

endmodule

>>> hdl/s20x_checker.sv
// ----------------------------------------------------------------------------
// s20x_checker
// Port-level checks for the Salsa20 byte stream engine, bound to the top level.
// ----------------------------------------------------------------------------
module s20x_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] data_out_o
);

  // a transaction in flight keeps the input side busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a byte is in flight");

  // a result needs at least the keystream read after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after acceptance");

  // going back to idle always coincides with a loaded result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("engine idle without delivering a result");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(data_out_o)))
    else $error("stalled result changed");

endmodule

bind salsa20_stream_xor_engine_top s20x_checker u_s20x_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .data_out_o  (data_out_o)
);

>>> test/salsa20_stream_xor_engine_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// salsa20_stream_xor_engine_top_test
// Streams bytes through the Salsa20 engine under several key and nonce
// settings, with restarts and random gaps on both sides, and checks every
// output byte against a keystream computed inside the bench.
// ----------------------------------------------------------------------------
module salsa20_stream_xor_engine_top_test;

  localparam logic [31:0] EXPAND_W0 = 32'h6170_7865;
  localparam logic [31:0] EXPAND_W1 = 32'h3320_646e;
  localparam logic [31:0] EXPAND_W2 = 32'h7962_2d32;
  localparam logic [31:0] EXPAND_W3 = 32'h6b20_6574;
  // word indexes a, b, c, d of the column then row quarter rounds, first at the top
  localparam logic [127:0] QUARTER_ORDER = 128'h048c_59d1_ae26_f37b_0123_5674_ab89_fcde;
  localparam int unsigned DOUBLE_ROUNDS = (s20x_pkg::ROUND_COUNT + 1) / 2;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } byte_item_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_in_i   = '0;
  logic        restart_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  data_out_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [5:0]  paddr       = '0;
  logic [63:0] pwdata      = '0;
  logic [63:0] prdata;
  logic        pready;

  salsa20_stream_xor_engine_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_in_i   (data_in_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_out_o  (data_out_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #10 clk_i = ~clk_i;

  // bench copy of the cipher state and the key/nonce registers
  logic [63:0] key_copy [4] = '{64'd0, 64'd0, 64'd0, 64'd0};
  logic [63:0] nonce_copy   = '0;
  logic [31:0] ks_words [16];
  logic [63:0] block_ctr    = '0;
  int unsigned ks_left      = 0;

  byte_item_t  pending_bytes [$];
  logic [7:0]  expected_bytes [$];
  int unsigned send_idle_pct  = 31;
  int unsigned recv_stall_pct = 31;
  int unsigned bytes_sent     = 0;
  int unsigned bytes_checked  = 0;
  int unsigned restarts_sent  = 0;
  int unsigned blocks_made    = 0;
  int unsigned settings_used  = 1;
  int unsigned mismatches     = 0;

  function automatic logic [31:0] rotate_left(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void make_keystream_block();
    logic [31:0] init_w [16];
    logic [31:0] x [16];
    logic [3:0]  a, b, c, d;
    init_w[0]  = EXPAND_W0;
    init_w[1]  = key_copy[0][31:0];
    init_w[2]  = key_copy[0][63:32];
    init_w[3]  = key_copy[1][31:0];
    init_w[4]  = key_copy[1][63:32];
    init_w[5]  = EXPAND_W1;
    init_w[6]  = nonce_copy[31:0];
    init_w[7]  = nonce_copy[63:32];
    init_w[8]  = block_ctr[31:0];
    init_w[9]  = block_ctr[63:32];
    init_w[10] = EXPAND_W2;
    init_w[11] = key_copy[2][31:0];
    init_w[12] = key_copy[2][63:32];
    init_w[13] = key_copy[3][31:0];
    init_w[14] = key_copy[3][63:32];
    init_w[15] = EXPAND_W3;
    for (int i = 0; i < 16; i++) x[i] = init_w[i];
    for (int dr = 0; dr < DOUBLE_ROUNDS; dr++) begin
      for (int q = 0; q < 8; q++) begin
        a = QUARTER_ORDER[127 - 16*q -: 4];
        b = QUARTER_ORDER[123 - 16*q -: 4];
        c = QUARTER_ORDER[119 - 16*q -: 4];
        d = QUARTER_ORDER[115 - 16*q -: 4];
        x[b] = x[b] ^ rotate_left(x[a] + x[d], 7);
        x[c] = x[c] ^ rotate_left(x[b] + x[a], 9);
        x[d] = x[d] ^ rotate_left(x[c] + x[b], 13);
        x[a] = x[a] ^ rotate_left(x[d] + x[c], 18);
      end
    end
    for (int i = 0; i < 16; i++) ks_words[i] = x[i] + init_w[i];
    block_ctr = block_ctr + 64'd1;
    blocks_made++;
  endfunction

  function automatic logic [7:0] encrypt_byte(input logic [7:0] plain, input logic restart);
    logic [5:0] pos;
    if (restart) begin
      block_ctr = '0;
      ks_left   = 0;
    end
    if (ks_left == 0) begin
      make_keystream_block();
      ks_left = 64;
    end
    pos = 6'(64 - ks_left);
    ks_left--;
    return plain ^ ks_words[pos[5:2]][{pos[1:0], 3'b000} +: 8];
  endfunction

  function automatic logic [63:0] random_word64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // read back the register just written
    @(posedge clk_i);
    if (prdata !== value) begin
      $error("prdata: expected %h, got %h", value, prdata);
      mismatches++;
    end
    case (idx)
      s20x_pkg::REG_KEY0:  key_copy[0] = value;
      s20x_pkg::REG_KEY1:  key_copy[1] = value;
      s20x_pkg::REG_KEY2:  key_copy[2] = value;
      s20x_pkg::REG_KEY3:  key_copy[3] = value;
      s20x_pkg::REG_NONCE: nonce_copy  = value;
      default: ;
    endcase
  endtask

  task automatic load_key_nonce(input logic [63:0] k0, input logic [63:0] k1,
                                input logic [63:0] k2, input logic [63:0] k3,
                                input logic [63:0] nonce);
    write_reg(s20x_pkg::REG_KEY0, k0);
    write_reg(s20x_pkg::REG_KEY1, k1);
    write_reg(s20x_pkg::REG_KEY2, k2);
    write_reg(s20x_pkg::REG_KEY3, k3);
    write_reg(s20x_pkg::REG_NONCE, nonce);
    settings_used++;
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid_i || expected_bytes.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // byte driver: predicts on every accepted transaction, then offers the next one
  always @(posedge clk_i) begin : byte_driver
    byte_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_bytes.push_back(encrypt_byte(data_in_i, restart_i));
        bytes_sent++;
        if (restart_i) restarts_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_valid_i <= 1'b1;
          data_in_i  <= nxt.data;
          restart_i  <= nxt.restart;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : byte_monitor
    logic [7:0] want;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $error("data_out: no transaction expected, got %h", data_out_o);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (data_out_o !== want) begin
            $error("data_out: expected %h, got %h", want, data_out_o);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    byte_item_t item;
    int unsigned phase_count;
    int unsigned msg_len;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset key and nonce: byte extremes, restart mid-block and twice in a row
    begin
      logic [7:0] seed_bytes [12];
      seed_bytes = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h55, 8'haa,
                     8'h7f, 8'hfe, 8'h00, 8'hff, 8'h3c, 8'hc3};
      for (int i = 0; i < 20; i++) begin
        item.data    = (i < 12) ? seed_bytes[i] : 8'(i * 8'h11);
        item.restart = (i == 8) || (i == 9) || (i == 15);
        pending_bytes.push_back(item);
      end
    end
    wait_drained();

    for (int phase = 1; phase <= 6; phase++) begin
      case (phase)
        1: load_key_nonce('1, '1, '1, '1, '1);
        2: load_key_nonce('0, '0, '0, '0, '0);
        3: load_key_nonce(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                          64'h1716151413121110, 64'h1f1e1d1c1b1a1918, 64'h8877665544332211);
        default: load_key_nonce(random_word64(), random_word64(), random_word64(),
                                random_word64(), random_word64());
      endcase
      // one phase runs without any gaps on either side
      send_idle_pct  = (phase == 4) ? 0 : 31;
      recv_stall_pct = (phase == 4) ? 0 : 31;
      phase_count = 0;
      while (phase_count < 70) begin
        // messages mostly start fresh; leftover keystream carries over otherwise
        msg_len = ($urandom_range(9) == 0) ? $urandom_range(100, 160) : $urandom_range(1, 70);
        for (int i = 0; i < msg_len; i++) begin
          item.data    = 8'($urandom_range(255));
          item.restart = (i == 0) ? ($urandom_range(99) < 70) : ($urandom_range(99) < 2);
          pending_bytes.push_back(item);
        end
        phase_count += msg_len;
      end
      wait_drained();
    end

    repeat (600) @(posedge clk_i);
    $display("%0d bytes checked over %0d key/nonce settings", bytes_checked, settings_used);
    $display("%0d keystream blocks generated, %0d restarts", blocks_made, restarts_sent);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
